// ===== src/msc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msc_pkg
// Shared constants, widths, codes and controller/datapath structs for the
// mean-shift centroid step unit.
// ----------------------------------------------------------------------------
package msc_pkg;

    localparam int HIST_BINS   = 16;
    localparam int MAX_WINDOW  = 256;
    localparam int WEIGHT_W    = 20;

    // bin span 256/HIST_BINS rounded down to a power of two
    localparam int BIN_SPAN    = 256 / HIST_BINS;
    localparam int BIN_SHIFT   = $clog2(BIN_SPAN + 1) - 1;
    localparam int EFF_BINS    = 256 >> BIN_SHIFT;
    localparam int BIN_IDX_W   = 8 - BIN_SHIFT;
    localparam int TABLE_DEPTH = 3 * EFF_BINS;

    localparam int CH_W        = 8;
    localparam int IDX_W       = 6;
    localparam int BANK_W      = IDX_W - BIN_IDX_W;
    localparam int WIN_W       = 9;
    localparam int CNT_W       = $clog2(MAX_WINDOW);
    localparam int POS_W       = 16;
    localparam int NEWPOS_W    = 17;
    localparam int OFS_W       = CNT_W + 2;
    localparam int SQ_W        = 2 * OFS_W - 1;
    localparam int CC_W        = 2 * CNT_W;
    localparam int WSUM_W      = WEIGHT_W + 2;
    localparam int PROD_W      = WSUM_W + OFS_W;
    localparam int ACC_W       = PROD_W + 2 * CNT_W;
    localparam int TOT_W       = WSUM_W + 2 * CNT_W;
    localparam int QUO_W       = NEWPOS_W;
    localparam int DIV_CNT_W   = $clog2(ACC_W + 1);
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_PIXEL = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW_WIDTH  = 2'd0,
        CFG_WINDOW_HEIGHT = 2'd1,
        CFG_START_COL     = 2'd2,
        CFG_START_ROW     = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic wt_write;   // load beat taken
        logic pix_take;   // pixel beat taken
        logic term_en;    // table read and squares
        logic prod_en;    // products and circle test
        logic acc_en;     // accumulate
        logic div_start;
        logic div_row;    // 0: column numerator, 1: row numerator
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic last;
        logic total_zero;
        logic div_done;
    } t_dp_sts;

endpackage

// ===== src/msc_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msc_in_if
// Input channel: weight load or window pixel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface msc_in_if import msc_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                mode;
    logic [IDX_W-1:0]    weight_index;
    logic [WEIGHT_W-1:0] weight_value;
    logic [CH_W-1:0]     channel_zero;
    logic [CH_W-1:0]     channel_one;
    logic [CH_W-1:0]     channel_two;

    modport source (
        output valid, mode, weight_index, weight_value,
               channel_zero, channel_one, channel_two,
        input  ready
    );
    modport sink (
        input  valid, mode, weight_index, weight_value,
               channel_zero, channel_one, channel_two,
        output ready
    );
endinterface

// ===== src/msc_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msc_out_if
// Result channel: new window position and shift, valid/ready handshake.
// ----------------------------------------------------------------------------
interface msc_out_if import msc_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [NEWPOS_W-1:0] new_col;
    logic signed [NEWPOS_W-1:0] new_row;
    logic signed [POS_W-1:0]    shift_col;
    logic signed [POS_W-1:0]    shift_row;
    logic                       zero_weight;

    modport source (
        output valid, new_col, new_row, shift_col, shift_row, zero_weight,
        input  ready
    );
    modport sink (
        input  valid, new_col, new_row, shift_col, shift_row, zero_weight,
        output ready
    );
endinterface

// ===== src/mean_shift_centroid_step_unit.sv =====
`timescale 1ns / 1ps
// A weight load beat is written while idle; a pixel beat passes through accept,
// table read, product and accumulate, and no new beat is taken until it is done.
// The last pixel of a window adds a decision step, two divisions (column, then row;
// ACC_W = 48 quotient steps each) and a load of the result register, which waits
// until any earlier result has been taken; zero total weight skips both divisions.
// Reset is synchronous, active low; weight banks are not cleared and must be loaded.
// ----------------------------------------------------------------------------
// mean_shift_centroid_step_unit
// One mean-shift step over a tracking window: weighted centroid of the
// pixels inside the circular window, output as a new window position.
// ----------------------------------------------------------------------------
module mean_shift_centroid_step_unit import msc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    msc_in_if.sink                i_item,
    msc_out_if.source             o_result
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    msc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .i_in_mode   (i_item.mode),
        .i_out_ready (o_result.ready),
        .i_sts       (sts),
        .o_in_ready  (i_item.ready),
        .o_out_valid (o_result.valid),
        .o_cmd       (cmd)
    );

    msc_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_weight_index (i_item.weight_index),
        .i_weight_value (i_item.weight_value),
        .i_channel_zero (i_item.channel_zero),
        .i_channel_one  (i_item.channel_one),
        .i_channel_two  (i_item.channel_two),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_new_col      (o_result.new_col),
        .o_new_row      (o_result.new_row),
        .o_shift_col    (o_result.shift_col),
        .o_shift_row    (o_result.shift_row),
        .o_zero_weight  (o_result.zero_weight)
    );

endmodule

// ===== src/msc_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msc_div
// Restoring divider, one quotient bit per cycle. Signed numerator over an
// unsigned nonzero denominator, truncating toward zero; low bits returned.
// ----------------------------------------------------------------------------
module msc_div import msc_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [ACC_W-1:0] i_num,
    input  logic [TOT_W-1:0]        i_den,
    output logic                    o_done,
    output logic [QUO_W-1:0]        o_quot
);

    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic                 r_neg;
    logic [ACC_W-1:0]     r_num;
    logic [TOT_W-1:0]     r_den;
    logic [TOT_W-1:0]     r_rem;
    logic [QUO_W-1:0]     r_quo;

    logic [ACC_W-1:0]     num_mag;
    logic [TOT_W:0]       rem_sh;
    logic [TOT_W:0]       rem_diff;
    logic                 ge;

    assign num_mag  = i_num[ACC_W-1] ? (~i_num + ACC_W'(1)) : i_num;
    assign rem_sh   = {r_rem, r_num[ACC_W-1]};
    assign rem_diff = rem_sh - {1'b0, r_den};
    assign ge       = (rem_sh >= {1'b0, r_den});

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = DIV_CNT_W'(ACC_W);
        end else if (r_busy) begin
            n_cnt = r_cnt - DIV_CNT_W'(1);
            if (r_cnt == DIV_CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_num[ACC_W-1];
            r_num <= num_mag;
            r_den <= i_den;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[ACC_W-2:0], 1'b0};
            r_rem <= ge ? rem_diff[TOT_W-1:0] : rem_sh[TOT_W-1:0];
            r_quo <= {r_quo[QUO_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? (~r_quo + QUO_W'(1)) : r_quo;

    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divider restarted while busy");

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("divider done without a running division");

    a_count_zero_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_busy && !i_start) |-> (r_cnt == '0))
        else $error("divider count left over while idle");

endmodule

// ===== src/msc_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msc_dp
// Datapath: configuration registers, weight banks, raster counters, the
// three-stage pixel path, accumulators, shared divider and result register.
// ----------------------------------------------------------------------------
module msc_dp import msc_pkg::*; (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [CFG_DATA_W-1:0]       i_cfg_data,
    input  logic [IDX_W-1:0]            i_weight_index,
    input  logic [WEIGHT_W-1:0]         i_weight_value,
    input  logic [CH_W-1:0]             i_channel_zero,
    input  logic [CH_W-1:0]             i_channel_one,
    input  logic [CH_W-1:0]             i_channel_two,
    input  t_dp_cmd                     i_cmd,
    output t_dp_sts                     o_sts,
    output logic signed [NEWPOS_W-1:0]  o_new_col,
    output logic signed [NEWPOS_W-1:0]  o_new_row,
    output logic signed [POS_W-1:0]     o_shift_col,
    output logic signed [POS_W-1:0]     o_shift_row,
    output logic                        o_zero_weight
);

    // configuration
    logic [WIN_W-1:0]        r_win_w, r_win_h;
    logic signed [POS_W-1:0] r_start_col, r_start_row;

    // weight banks, one per colour channel
    logic [WEIGHT_W-1:0]     r_tab [3][EFF_BINS];

    // raster position
    logic [CNT_W-1:0]        r_col, r_row;

    // pixel path
    logic [BIN_IDX_W-1:0]    r_b0, r_b1, r_b2;
    logic signed [OFS_W-1:0] r_di, r_dj;
    logic                    r_last;
    logic [WSUM_W-1:0]       r_wt;
    logic [SQ_W-1:0]         r_di2, r_dj2;
    logic [CC_W-1:0]         r_cc;
    logic                    r_inside;
    logic signed [PROD_W-1:0] r_pc, r_pr;

    // accumulators
    logic signed [ACC_W-1:0] r_col_sum, r_row_sum;
    logic [TOT_W-1:0]        r_total;

    // division results
    logic                    r_div_row;
    logic [QUO_W-1:0]        r_q_col, r_q_row;

    // result register
    logic signed [NEWPOS_W-1:0] r_new_col, r_new_row;
    logic signed [POS_W-1:0]    r_shift_col, r_shift_row;
    logic                       r_zero;

    logic [WIN_W-1:0]        w_eff, h_eff, c_full;
    logic [CNT_W-1:0]        c;
    logic [WIN_W-1:0]        col_p1, row_p1;
    logic                    row_end, last;
    logic signed [OFS_W-1:0] di, dj;
    logic signed [2*OFS_W-1:0] di_sq, dj_sq;
    logic [CC_W-1:0]         cc;
    logic [SQ_W:0]           sum_sq;
    logic signed [PROD_W:0]  pc_full, pr_full;
    logic [BANK_W-1:0]       wr_bank;
    logic                    div_done;
    logic [QUO_W-1:0]        div_quot;
    logic signed [ACC_W-1:0] div_num;
    logic [QUO_W-1:0]        sc, sr;

    assign w_eff = (r_win_w == '0) ? WIN_W'(1) :
                   (r_win_w > WIN_W'(MAX_WINDOW)) ? WIN_W'(MAX_WINDOW) : r_win_w;
    assign h_eff = (r_win_h == '0) ? WIN_W'(1) :
                   (r_win_h > WIN_W'(MAX_WINDOW)) ? WIN_W'(MAX_WINDOW) : r_win_h;
    // circle centre in doubled coordinates, taken from the height for both axes
    assign c_full = h_eff - WIN_W'(1);
    assign c      = c_full[CNT_W-1:0];

    assign col_p1  = {1'b0, r_col} + WIN_W'(1);
    assign row_p1  = {1'b0, r_row} + WIN_W'(1);
    assign row_end = (col_p1 >= w_eff);
    assign last    = row_end && (row_p1 >= h_eff);

    assign di = $signed({1'b0, r_row, 1'b0}) - $signed({2'b00, c});
    assign dj = $signed({1'b0, r_col, 1'b0}) - $signed({2'b00, c});

    assign di_sq = r_di * r_di;
    assign dj_sq = r_dj * r_dj;
    assign cc    = c * c;

    assign sum_sq  = {1'b0, r_di2} + {1'b0, r_dj2};
    assign pc_full = $signed({1'b0, r_wt}) * r_dj;
    assign pr_full = $signed({1'b0, r_wt}) * r_di;

    assign wr_bank = i_weight_index[IDX_W-1:BIN_IDX_W];

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_w     <= WIN_W'(64);
            r_win_h     <= WIN_W'(64);
            r_start_col <= '0;
            r_start_row <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_WINDOW_WIDTH:  r_win_w     <= i_cfg_data[WIN_W-1:0];
                CFG_WINDOW_HEIGHT: r_win_h     <= i_cfg_data[WIN_W-1:0];
                CFG_START_COL:     r_start_col <= i_cfg_data;
                CFG_START_ROW:     r_start_row <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // weight banks: contents are undefined until loaded
    always_ff @(posedge i_clk) begin
        if (i_cmd.wt_write && ({1'b0, i_weight_index} < (IDX_W+1)'(TABLE_DEPTH))) begin
            r_tab[wr_bank][i_weight_index[BIN_IDX_W-1:0]] <= i_weight_value;
        end
    end

    // counters and accumulators
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_col_sum <= '0;
            r_row_sum <= '0;
            r_total   <= '0;
        end else begin
            if (i_cmd.pix_take) begin
                if (last) begin
                    r_col <= '0;
                    r_row <= '0;
                end else if (row_end) begin
                    r_col <= '0;
                    r_row <= r_row + CNT_W'(1);
                end else begin
                    r_col <= r_col + CNT_W'(1);
                end
            end
            if (i_cmd.load_out) begin
                r_col_sum <= '0;
                r_row_sum <= '0;
                r_total   <= '0;
            end else if (i_cmd.acc_en && r_inside) begin
                r_col_sum <= r_col_sum + {{(ACC_W-PROD_W){r_pc[PROD_W-1]}}, r_pc};
                r_row_sum <= r_row_sum + {{(ACC_W-PROD_W){r_pr[PROD_W-1]}}, r_pr};
                r_total   <= r_total + {{(TOT_W-WSUM_W){1'b0}}, r_wt};
            end
        end
    end

    // pixel path stages
    always_ff @(posedge i_clk) begin
        if (i_cmd.pix_take) begin
            r_b0   <= i_channel_zero[CH_W-1:BIN_SHIFT];
            r_b1   <= i_channel_one[CH_W-1:BIN_SHIFT];
            r_b2   <= i_channel_two[CH_W-1:BIN_SHIFT];
            r_di   <= di;
            r_dj   <= dj;
            r_last <= last;
        end
        if (i_cmd.term_en) begin
            r_wt  <= {2'b00, r_tab[0][r_b0]} + {2'b00, r_tab[1][r_b1]}
                   + {2'b00, r_tab[2][r_b2]};
            r_di2 <= di_sq[SQ_W-1:0];
            r_dj2 <= dj_sq[SQ_W-1:0];
            r_cc  <= cc;
        end
        if (i_cmd.prod_en) begin
            r_inside <= (sum_sq < {{(SQ_W+1-CC_W){1'b0}}, r_cc});
            r_pc     <= pc_full[PROD_W-1:0];
            r_pr     <= pr_full[PROD_W-1:0];
        end
    end

    // halved offset sums, floor toward minus infinity
    assign div_num = i_cmd.div_row ? (r_row_sum >>> 1) : (r_col_sum >>> 1);

    msc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (div_num),
        .i_den   (r_total),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_row <= 1'b0;
        end else if (i_cmd.div_start) begin
            r_div_row <= i_cmd.div_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (div_done) begin
            if (r_div_row) begin
                r_q_row <= div_quot;
            end else begin
                r_q_col <= div_quot;
            end
        end
    end

    assign sc = (r_total == '0) ? '0 : r_q_col;
    assign sr = (r_total == '0) ? '0 : r_q_row;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_new_col   <= {r_start_col[POS_W-1], r_start_col} + sc;
            r_new_row   <= {r_start_row[POS_W-1], r_start_row} + sr;
            r_shift_col <= sc[POS_W-1:0];
            r_shift_row <= sr[POS_W-1:0];
            r_zero      <= (r_total == '0);
        end
    end

    assign o_sts.last       = r_last;
    assign o_sts.total_zero = (r_total == '0);
    assign o_sts.div_done   = div_done;

    assign o_new_col     = r_new_col;
    assign o_new_row     = r_new_row;
    assign o_shift_col   = r_shift_col;
    assign o_shift_row   = r_shift_row;
    assign o_zero_weight = r_zero;

endmodule

// ===== src/msc_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msc_ctrl
// Controller: sequences one beat at a time through the pixel stages, two
// divisions at window end (none at zero weight), the result register handoff.
// ----------------------------------------------------------------------------
module msc_ctrl import msc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_in_mode,
    input  logic    i_out_ready,
    input  t_dp_sts i_sts,
    output logic    o_in_ready,
    output logic    o_out_valid,
    output t_dp_cmd o_cmd
);

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_TERM = 8'b0000_0010,
        ST_PROD = 8'b0000_0100,
        ST_ACC  = 8'b0000_1000,
        ST_FIN  = 8'b0001_0000,
        ST_DIVC = 8'b0010_0000,
        ST_DIVR = 8'b0100_0000,
        ST_OUT  = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   in_fire;

    assign o_in_ready = (r_state == ST_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    if (i_in_mode == MODE_PIXEL) begin
                        o_cmd.pix_take = 1'b1;
                        n_state        = ST_TERM;
                    end else begin
                        o_cmd.wt_write = 1'b1;
                    end
                end
            end
            ST_TERM: begin
                o_cmd.term_en = 1'b1;
                n_state       = ST_PROD;
            end
            ST_PROD: begin
                o_cmd.prod_en = 1'b1;
                n_state       = ST_ACC;
            end
            ST_ACC: begin
                o_cmd.acc_en = 1'b1;
                n_state      = i_sts.last ? ST_FIN : ST_IDLE;
            end
            ST_FIN: begin
                // zero total weight skips both divisions
                if (i_sts.total_zero) begin
                    n_state = ST_OUT;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = ST_DIVC;
                end
            end
            ST_DIVC: begin
                if (i_sts.div_done) begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_row   = 1'b1;
                    n_state         = ST_DIVR;
                end
            end
            ST_DIVR: begin
                o_cmd.div_row = 1'b1;
                if (i_sts.div_done) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> (!r_out_valid || i_out_ready))
        else $error("result register overwritten before its beat left");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.div_start |-> !i_sts.total_zero)
        else $error("division started with zero total weight");

    a_pixel_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && (i_in_mode == MODE_PIXEL)) |=> (r_state == ST_TERM))
        else $error("pixel beat did not enter the pixel path");

    a_done_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sts.div_done |-> (r_state == ST_DIVC || r_state == ST_DIVR))
        else $error("divider finished outside a division state");

endmodule

// ===== tb/centroid_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// centroid_checker
// Watches the config port and both channels of the mean-shift step unit.
// It tracks the weight bins, window counters and moment sums. When a window
// closes, it queues the new position it expects. It then compares each
// result beat against that queue, field by field.
// ----------------------------------------------------------------------------
module centroid_checker import msc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    msc_in_if                     i_item,
    msc_out_if                    i_result,
    output int                    o_fail_count,
    output int                    o_pending
);

    typedef struct packed {
        logic signed [NEWPOS_W-1:0] new_col;
        logic signed [NEWPOS_W-1:0] new_row;
        logic signed [POS_W-1:0]    shift_col;
        logic signed [POS_W-1:0]    shift_row;
        logic                       zero_weight;
    } t_centroid;

    logic [WEIGHT_W-1:0]     bin_weight [TABLE_DEPTH];
    longint                  col_moment;
    longint                  row_moment;
    longint                  mass;
    int                      col_pos;
    int                      row_pos;
    logic [WIN_W-1:0]        width_reg;
    logic [WIN_W-1:0]        height_reg;
    logic signed [POS_W-1:0] origin_col;
    logic signed [POS_W-1:0] origin_row;
    t_centroid               centroid_q[$];
    int                      fail_total;

    function automatic int window_span(input logic [WIN_W-1:0] v);
        if (v == 0) return 1;
        if (v > MAX_WINDOW) return MAX_WINDOW;
        return int'(v);
    endfunction

    function automatic void clear_window();
        col_moment = 0;
        row_moment = 0;
        mass       = 0;
        col_pos    = 0;
        row_pos    = 0;
    endfunction

    function automatic void take_pixel(input logic [CH_W-1:0] ch0, ch1, ch2);
        int        w;
        int        h;
        longint    c;
        longint    di;
        longint    dj;
        longint    wt;
        longint    sc;
        longint    sr;
        longint    base;
        logic      closes;
        t_centroid res;
        w  = window_span(width_reg);
        h  = window_span(height_reg);
        // circle centre comes from the height on both axes, doubled coords
        c  = h - 1;
        di = 2 * row_pos - c;
        dj = 2 * col_pos - c;
        if (di * di + dj * dj < c * c) begin
            wt = bin_weight[ch0 >> BIN_SHIFT];
            wt += bin_weight[EFF_BINS + (ch1 >> BIN_SHIFT)];
            wt += bin_weight[2 * EFF_BINS + (ch2 >> BIN_SHIFT)];
            col_moment += wt * dj;
            row_moment += wt * di;
            mass       += wt;
        end
        // counters past the end (window shrunk) close the row/window at once
        closes = (col_pos + 1 >= w) && (row_pos + 1 >= h);
        if (col_pos + 1 >= w) begin
            col_pos = 0;
            row_pos++;
        end else begin
            col_pos++;
        end
        if (closes) begin
            if (mass == 0) begin
                sc = 0;
                sr = 0;
            end else begin
                // floor halving, then truncating divide
                sc = (col_moment >>> 1) / mass;
                sr = (row_moment >>> 1) / mass;
            end
            base = origin_col;
            base = base + sc;
            res.new_col = base[NEWPOS_W-1:0];
            base = origin_row;
            base = base + sr;
            res.new_row = base[NEWPOS_W-1:0];
            res.shift_col   = sc[POS_W-1:0];
            res.shift_row   = sr[POS_W-1:0];
            res.zero_weight = (mass == 0);
            centroid_q.push_back(res);
            clear_window();
        end
    endfunction

    function automatic void compare_field(input string field,
                                          input logic signed [63:0] want,
                                          input logic signed [63:0] got);
        if (want !== got) begin
            if (fail_total < 10)
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
            fail_total++;
        end
    endfunction

    function automatic void check_result();
        t_centroid want;
        if (centroid_q.size() == 0) begin
            if (fail_total < 10)
                $display("%0t: result beat with no window closed", $time);
            fail_total++;
        end else begin
            want = centroid_q.pop_front();
            compare_field("new_col", want.new_col, i_result.new_col);
            compare_field("new_row", want.new_row, i_result.new_row);
            compare_field("shift_col", want.shift_col, i_result.shift_col);
            compare_field("shift_row", want.shift_row, i_result.shift_row);
            compare_field("zero_weight", want.zero_weight, i_result.zero_weight);
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_window();
            width_reg  = 9'd64;
            height_reg = 9'd64;
            origin_col = '0;
            origin_row = '0;
        end else begin
            // results first, so a beat out never pairs with an item taken now
            if (i_result.valid && i_result.ready)
                check_result();
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_WINDOW_WIDTH:  width_reg  = i_cfg_data[WIN_W-1:0];
                    CFG_WINDOW_HEIGHT: height_reg = i_cfg_data[WIN_W-1:0];
                    CFG_START_COL:     origin_col = i_cfg_data;
                    CFG_START_ROW:     origin_row = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_item.valid && i_item.ready) begin
                if (i_item.mode == MODE_PIXEL)
                    take_pixel(i_item.channel_zero, i_item.channel_one, i_item.channel_two);
                else if (i_item.weight_index < TABLE_DEPTH)
                    bin_weight[i_item.weight_index] = i_item.weight_value;
            end
        end
        o_pending    <= centroid_q.size();
        o_fail_count <= fail_total;
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the mean-shift step unit. It fills the weight bins, then runs
// a few hand-picked windows. After those come random windows of many shapes,
// with bin reloads mixed into the pixel stream. Both handshakes idle at
// random, and one stretch holds the result channel off. The checker does the
// prediction; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;
    import msc_pkg::*;

    localparam int TARGET_BEATS  = 850;
    localparam int MAX_GAP       = 12;
    localparam int SETTLE_CYCLES = 110;
    localparam int HOLD_CYCLES   = 300;
    localparam int IDLE_LIMIT    = 3000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    t_cfg_idx              cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    fail_count;
    int                    pending;
    int                    beats_sent;
    int                    idle_cycles;
    bit                    tx_burst;
    bit                    rx_burst;
    bit                    hold_request;

    msc_in_if  item_ch ();
    msc_out_if result_ch ();

    mean_shift_centroid_step_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_item      (item_ch),
        .o_result    (result_ch)
    );

    centroid_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_item       (item_ch),
        .i_result     (result_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic int window_span(input logic [WIN_W-1:0] v);
        if (v == 0) return 1;
        if (v > MAX_WINDOW) return MAX_WINDOW;
        return int'(v);
    endfunction

    function automatic logic [WEIGHT_W-1:0] weight_draw();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return WEIGHT_W'($urandom);
        endcase
    endfunction

    function automatic logic [CH_W-1:0] byte_draw();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return CH_W'($urandom);
        endcase
    endfunction

    function automatic logic [POS_W-1:0] origin_draw();
        case ($urandom_range(0, 6))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            default: return POS_W'($urandom);
        endcase
    endfunction

    // valid stays high across back-to-back beats; only dropped for a gap
    task automatic send_beat(input logic mode, input logic [IDX_W-1:0] idx,
                             input logic [WEIGHT_W-1:0] value,
                             input logic [CH_W-1:0] c0, c1, c2);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        item_ch.valid        <= 1'b1;
        item_ch.mode         <= mode;
        item_ch.weight_index <= idx;
        item_ch.weight_value <= value;
        item_ch.channel_zero <= c0;
        item_ch.channel_one  <= c1;
        item_ch.channel_two  <= c2;
        do @(posedge i_clk); while (item_ch.ready !== 1'b1);
        beats_sent++;
    endtask

    task automatic send_load(input logic [IDX_W-1:0] idx, input logic [WEIGHT_W-1:0] value);
        send_beat(MODE_LOAD, idx, value, byte_draw(), byte_draw(), byte_draw());
    endtask

    task automatic send_pixel(input logic [CH_W-1:0] c0, c1, c2);
        send_beat(MODE_PIXEL, IDX_W'($urandom), WEIGHT_W'($urandom), c0, c1, c2);
    endtask

    // wait for every closed window to report, then let trailing pixels retire
    task automatic settle_block();
        item_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_config(input logic [WIN_W-1:0] w, h,
                                input logic [POS_W-1:0] col, row);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_WINDOW_WIDTH;
        cfg_data  <= {7'($urandom), w};
        @(posedge i_clk);
        cfg_index <= CFG_WINDOW_HEIGHT;
        cfg_data  <= {7'($urandom), h};
        @(posedge i_clk);
        cfg_index <= CFG_START_COL;
        cfg_data  <= col;
        @(posedge i_clk);
        cfg_index <= CFG_START_ROW;
        cfg_data  <= row;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic run_phase(input bit squeeze);
        logic [WIN_W-1:0] w_reg;
        logic [WIN_W-1:0] h_reg;
        int               pixels;
        int               shape;
        int               area;
        settle_block();
        tx_burst = squeeze || ($urandom_range(0, 3) == 0);
        rx_burst = ($urandom_range(0, 3) == 0);
        shape    = $urandom_range(0, 9);
        if (squeeze) begin
            // one-pixel windows: a result per beat while the sink is held off
            w_reg  = WIN_W'($urandom_range(0, 1));
            h_reg  = WIN_W'(1);
            pixels = 40;
            hold_request = 1'b1;
        end else if (shape == 0) begin
            // tallest window, left open; the next setting shrinks it
            w_reg  = WIN_W'($urandom_range(0, 2));
            h_reg  = WIN_W'($urandom_range(MAX_WINDOW, 511));
            pixels = $urandom_range(4, 40);
        end else if (shape == 1) begin
            w_reg  = WIN_W'($urandom_range(MAX_WINDOW, 511));
            h_reg  = WIN_W'($urandom_range(0, 3));
            pixels = $urandom_range(4, 40);
        end else begin
            w_reg  = WIN_W'($urandom_range(0, 9));
            h_reg  = WIN_W'($urandom_range(0, 9));
            area   = window_span(w_reg) * window_span(h_reg);
            pixels = area * $urandom_range(1, 3);
            if ($urandom_range(0, 3) == 0)
                pixels += $urandom_range(1, area);
        end
        write_config(w_reg, h_reg, origin_draw(), origin_draw());
        repeat (pixels) begin
            if ($urandom_range(0, 11) == 0)
                send_load(IDX_W'($urandom), weight_draw());
            else
                send_pixel(byte_draw(), byte_draw(), byte_draw());
        end
    endtask

    initial begin : result_sink
        int stall;
        result_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            stall = rx_burst ? 0 : $urandom_range(0, MAX_GAP);
            if (hold_request) begin
                hold_request = 1'b0;
                stall = HOLD_CYCLES;
            end
            if (stall > 0) begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            result_ch.ready <= 1'b1;
            do @(posedge i_clk); while (result_ch.valid !== 1'b1);
        end
    end

    always @(posedge i_clk) begin
        if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        int k;
        i_rst_n              <= 1'b0;
        cfg_we               <= 1'b0;
        cfg_index            <= CFG_WINDOW_WIDTH;
        cfg_data             <= '0;
        item_ch.valid        <= 1'b0;
        item_ch.mode         <= MODE_LOAD;
        item_ch.weight_index <= '0;
        item_ch.weight_value <= '0;
        item_ch.channel_zero <= '0;
        item_ch.channel_one  <= '0;
        item_ch.channel_two  <= '0;
        tx_burst     = 1'b0;
        rx_burst     = 1'b0;
        hold_request = 1'b0;
        beats_sent   = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // every bin gets a value before any pixel reads it;
        // bin 0 is zero and the top bin is full scale in each channel
        for (k = 0; k < TABLE_DEPTH; k++) begin
            if (k % EFF_BINS == 0)
                send_load(IDX_W'(k), '0);
            else if (k % EFF_BINS == EFF_BINS - 1)
                send_load(IDX_W'(k), '1);
            else
                send_load(IDX_W'(k), weight_draw());
        end
        // indexes past the table are dropped
        send_load(IDX_W'(TABLE_DEPTH), weight_draw());
        send_load('1, '1);

        // zero size acts as one: height one leaves the circle empty
        settle_block();
        write_config('0, '0, 16'h7FFF, 16'h8000);
        send_pixel('1, '1, '1);

        // small window at extreme start, with reloads mid-window
        settle_block();
        write_config(9'd3, 9'd4, 16'h8000, 16'h7FFF);
        for (k = 0; k < 12; k++) begin
            if (k[0])
                send_pixel(8'hFF, 8'h00, 8'hFF);
            else
                send_pixel(8'h00, 8'hFF, 8'h00);
            if (k == 5) begin
                send_load(IDX_W'(EFF_BINS + 1), '1);
                send_load('1, '0);
            end
        end

        // every pixel lands in the zero bins: empty total with a real circle
        settle_block();
        write_config(9'd2, 9'd3, 16'h0000, 16'hFFFF);
        repeat (6)
            send_pixel(CH_W'($urandom_range(0, EFF_BINS - 1)),
                       CH_W'($urandom_range(0, EFF_BINS - 1)),
                       CH_W'($urandom_range(0, EFF_BINS - 1)));

        k = 0;
        while (beats_sent < TARGET_BEATS) begin
            run_phase(k == 2);
            k++;
        end

        settle_block();
        if (fail_count == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
